/* hw/rtl/nhbs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nhbs_pkg
// Shared types and constants for the node heartbeat supervisor.
// ----------------------------------------------------------------------------
package nhbs_pkg;

    // Supervised nodes and miss counter width
    localparam int NODE_COUNT  = 4;
    localparam int COUNT_WIDTH = 8;

    // Fixed field widths of the channels and configuration registers
    localparam int MASK_WIDTH      = 4;
    localparam int LIMIT_WIDTH     = 8;
    localparam int CFG_COUNT       = 4;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 8;

    // Width used to compare a counter against a limit
    localparam int CMP_WIDTH = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(3);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = {COUNT_WIDTH{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MISS_LIMIT_NODE0 = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MISS_LIMIT_NODE1 = CFG_INDEX_WIDTH'(1);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MISS_LIMIT_NODE2 = CFG_INDEX_WIDTH'(2);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MISS_LIMIT_NODE3 = CFG_INDEX_WIDTH'(3);

    typedef struct packed {
        logic [MASK_WIDTH-1:0] heartbeat_seen;
        logic [MASK_WIDTH-1:0] sync_seen;
    } nhbs_in_t;

    typedef struct packed {
        logic [MASK_WIDTH-1:0] reset_mask;
        logic                  send_reset;
        logic [MASK_WIDTH-1:0] synced_mask;
        logic                  send_sync_ack;
    } nhbs_out_t;

    // Per-node status after the heartbeat phase
    typedef struct packed {
        logic hb_synced;
        logic reset_req;
    } nhbs_node_stat_t;

endpackage : nhbs_pkg
`default_nettype wire

/* hw/rtl/nhbs_node_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nhbs_node_cell
// Miss counter and sync flag of one supervised node.
// ----------------------------------------------------------------------------
module nhbs_node_cell
    import nhbs_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   step_en,
    input  wire logic                   heartbeat,
    input  wire logic                   sync_set,
    input  wire logic [LIMIT_WIDTH-1:0] miss_limit,
    output nhbs_node_stat_t             stat
);

    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   synced_reg;
    logic                   synced_next;
    logic [COUNT_WIDTH-1:0] count_inc;

    // Saturating increment on a miss
    assign count_inc = (count_reg < COUNT_MAX) ? count_reg + COUNT_WIDTH'(1) : count_reg;

    always_comb begin
        count_next     = count_reg;
        stat.hb_synced = synced_reg;
        stat.reset_req = 1'b0;
        if (!heartbeat) begin
            count_next = count_inc;
            if (CMP_WIDTH'(count_inc) >= CMP_WIDTH'(miss_limit)) begin
                stat.hb_synced = 1'b0;
                stat.reset_req = 1'b1;
                count_next     = '0;
            end
        end else if (synced_reg) begin
            count_next = '0;
        end else begin
            stat.reset_req = 1'b1;
        end
        synced_next = stat.hb_synced | sync_set;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            synced_reg <= 1'b0;
        end else if (step_en) begin
            count_reg  <= count_next;
            synced_reg <= synced_next;
        end
    end

endmodule : nhbs_node_cell
`default_nettype wire

/* hw/rtl/node_heartbeat_supervisor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// node_heartbeat_supervisor
// Heartbeat watchdog and resync tracker for a set of network nodes.
// ----------------------------------------------------------------------------
// One input item is one check period: which nodes sent a heartbeat and which
// sent a sync request. Each item yields exactly one result item with the
// nodes to reset, the nodes in sync afterwards and a sync acknowledge. An
// item is captured in an input register, evaluated by the per-node cells
// against their miss counters and sync flags once the result register is
// free or draining, and lands in the result register, which drives m_valid;
// one item is taken every cycle as long as the result side keeps up.
// The result register lets a new item enter while a result waits. Miss
// limits are written through the cfg port (index 0..3 for nodes 0..3) and
// must only be changed while no item is in flight.
// ----------------------------------------------------------------------------
module node_heartbeat_supervisor
    import nhbs_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // input channel
    input  wire logic                       s_valid,
    output      logic                       s_ready,
    input  wire nhbs_in_t                   s_data,
    // result channel
    output      logic                       m_valid,
    input  wire logic                       m_ready,
    output      nhbs_out_t                  m_data,
    // configuration writes
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_wdata
);

    // Miss limit registers
    logic [LIMIT_WIDTH-1:0] limit_reg [CFG_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < CFG_COUNT; k++) begin
                limit_reg[k] <= LIMIT_RESET;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MISS_LIMIT_NODE0: limit_reg[0] <= cfg_wdata[LIMIT_WIDTH-1:0];
                REG_MISS_LIMIT_NODE1: limit_reg[1] <= cfg_wdata[LIMIT_WIDTH-1:0];
                REG_MISS_LIMIT_NODE2: limit_reg[2] <= cfg_wdata[LIMIT_WIDTH-1:0];
                REG_MISS_LIMIT_NODE3: limit_reg[3] <= cfg_wdata[LIMIT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // Input register and handshake
    nhbs_in_t  in_data_reg;
    logic      in_valid_reg;
    nhbs_out_t out_data_reg;
    logic      out_valid_reg;
    nhbs_out_t out_data_next;
    logic      advance;

    // Evaluate the held item when the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Per-node cells
    logic [NODE_COUNT-1:0] hb_vec;
    logic [NODE_COUNT-1:0] sy_vec;
    logic [NODE_COUNT-1:0] mid_synced;
    logic [NODE_COUNT-1:0] rst_vec;
    logic [NODE_COUNT-1:0] sync_set;
    logic [NODE_COUNT-1:0] final_synced;
    logic                  any_unsynced;
    nhbs_node_stat_t       node_stat [NODE_COUNT];

    for (genvar i = 0; i < NODE_COUNT; i++) begin : g_node
        logic [LIMIT_WIDTH-1:0] node_limit;

        // Nodes past the masks see no heartbeat or sync and use the reset limit
        if (i < MASK_WIDTH) begin : g_in
            assign hb_vec[i] = in_data_reg.heartbeat_seen[i];
            assign sy_vec[i] = in_data_reg.sync_seen[i];
        end else begin : g_none
            assign hb_vec[i] = 1'b0;
            assign sy_vec[i] = 1'b0;
        end

        if (i < CFG_COUNT) begin : g_lim
            assign node_limit = limit_reg[i];
        end else begin : g_deflim
            assign node_limit = LIMIT_RESET;
        end

        nhbs_node_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .step_en    (advance),
            .heartbeat  (hb_vec[i]),
            .sync_set   (sync_set[i]),
            .miss_limit (node_limit),
            .stat       (node_stat[i])
        );

        assign mid_synced[i] = node_stat[i].hb_synced;
        assign rst_vec[i]    = node_stat[i].reset_req;
    end

    // Sync phase: only while some node is out of sync
    assign any_unsynced = ~&mid_synced;
    assign sync_set     = sy_vec & {NODE_COUNT{any_unsynced}};
    assign final_synced = mid_synced | sync_set;

    // Fold node vectors into the fixed-width masks
    for (genvar j = 0; j < MASK_WIDTH; j++) begin : g_mask
        if (j < NODE_COUNT) begin : g_live
            assign out_data_next.reset_mask[j]  = rst_vec[j];
            assign out_data_next.synced_mask[j] = final_synced[j];
        end else begin : g_pad
            assign out_data_next.reset_mask[j]  = 1'b0;
            assign out_data_next.synced_mask[j] = 1'b0;
        end
    end

    assign out_data_next.send_reset    = |rst_vec;
    assign out_data_next.send_sync_ack = any_unsynced && (&final_synced);

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule : node_heartbeat_supervisor
`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: node heartbeat supervisor testbench
// Drives check periods (heartbeat and sync masks) into the supervisor over a
// valid/ready channel, predicts every status item from a cycle-free model of
// the miss counters and sync flags, and checks the status items in order.
// The miss limits are reprogrammed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import nhbs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 11;
    localparam int IDLE_PCT       = 31;
    localparam int RX_HOLD_CYCLES = 150;
    localparam int SETTLE_CYCLES  = 4;
    localparam int CYCLE_LIMIT    = 100000;

    // Clock, reset and every block input start at a known value
    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    nhbs_in_t                   s_data    = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    nhbs_out_t                  m_data;
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;

    // Periods waiting to be offered, and status items waiting to come back
    nhbs_in_t  pending_periods[$];
    nhbs_out_t expected_status[$];
    nhbs_out_t status_want;

    // Supervisor model state: limits, miss counters and sync flags
    logic [LIMIT_WIDTH-1:0] limit_reg [CFG_COUNT] = '{default: LIMIT_RESET};
    logic [COUNT_WIDTH-1:0] miss_cnt  [NODE_COUNT] = '{default: '0};
    logic [NODE_COUNT-1:0]  node_in_sync = '0;

    // Flow control knobs, written only by the stimulus process
    logic tx_steady   = 1'b0;
    logic rx_steady   = 1'b0;
    int   hold_req_id = 0;

    // Receiver hold-off bookkeeping, owned by the monitor
    int   hold_seen_id = 0;
    int   hold_left    = 0;

    int   error_count = 0;
    int   cycle_count = 0;

    node_heartbeat_supervisor u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Model of one check period. Heartbeat phase first: a miss bumps the
    // counter (saturating) and resets the node once it reaches its limit; a
    // heartbeat clears the counter of a synced node and resets an unsynced
    // one. Sync phase only runs while some node is out of sync, so a node
    // knocked out in this period can come straight back if its sync bit is
    // set. The acknowledge needs that phase to run and end with all synced.
    // ------------------------------------------------------------------------
    function automatic nhbs_out_t supervise_period(nhbs_in_t period);
        nhbs_out_t status;
        status = '0;
        for (int n = 0; n < NODE_COUNT; n++) begin
            if (!period.heartbeat_seen[n]) begin
                if (miss_cnt[n] != COUNT_MAX)
                    miss_cnt[n] = miss_cnt[n] + 1'b1;
                if (miss_cnt[n] >= limit_reg[n]) begin
                    node_in_sync[n]      = 1'b0;
                    status.reset_mask[n] = 1'b1;
                    miss_cnt[n]          = '0;
                end
            end else if (node_in_sync[n]) begin
                miss_cnt[n] = '0;
            end else begin
                status.reset_mask[n] = 1'b1;
            end
        end
        if (!(&node_in_sync)) begin
            for (int n = 0; n < NODE_COUNT; n++)
                if (period.sync_seen[n])
                    node_in_sync[n] = 1'b1;
            status.send_sync_ack = &node_in_sync;
        end
        status.synced_mask = node_in_sync;
        status.send_reset  = |status.reset_mask;
        return status;
    endfunction

    // Random period: each heartbeat bit missing and each sync bit set with
    // the given percentage
    function automatic nhbs_in_t random_period(int miss_pct, int sync_pct);
        nhbs_in_t period;
        for (int n = 0; n < MASK_WIDTH; n++) begin
            period.heartbeat_seen[n] = ($urandom_range(99) >= miss_pct);
            period.sync_seen[n]      = ($urandom_range(99) < sync_pct);
        end
        return period;
    endfunction

    // Mostly small limits so resets happen often, now and then an extreme
    function automatic logic [LIMIT_WIDTH-1:0] random_limit();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return LIMIT_WIDTH'($urandom_range(255, 9));
            default: return LIMIT_WIDTH'($urandom_range(8, 1));
        endcase
    endfunction

    task automatic queue_period(logic [MASK_WIDTH-1:0] hb, logic [MASK_WIDTH-1:0] sy);
        nhbs_in_t period;
        period.heartbeat_seen = hb;
        period.sync_seen      = sy;
        pending_periods.push_back(period);
    endtask

    // Hold until every queued period has gone in and every status item has
    // come back, then let the pipeline settle
    task automatic wait_quiet();
        while (pending_periods.size() != 0 || s_valid || expected_status.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one limit register; only called while the block is idle, so the
    // model copy can follow at once
    task automatic write_miss_limit(logic [CFG_INDEX_WIDTH-1:0] idx,
                                    logic [LIMIT_WIDTH-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        limit_reg[idx] = value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic program_limits(logic [LIMIT_WIDTH-1:0] lim0, logic [LIMIT_WIDTH-1:0] lim1,
                                  logic [LIMIT_WIDTH-1:0] lim2, logic [LIMIT_WIDTH-1:0] lim3);
        write_miss_limit(REG_MISS_LIMIT_NODE0, lim0);
        write_miss_limit(REG_MISS_LIMIT_NODE1, lim1);
        write_miss_limit(REG_MISS_LIMIT_NODE2, lim2);
        write_miss_limit(REG_MISS_LIMIT_NODE3, lim3);
    endtask

    // ------------------------------------------------------------------------
    // Driver: predict each period at the edge it is accepted, hold a stalled
    // item, otherwise offer the next pending period unless idling this cycle.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_status.push_back(supervise_period(s_data));
            if (!s_valid || s_ready) begin
                if (pending_periods.size() != 0 &&
                    (tx_steady || $urandom_range(99) >= IDLE_PCT)) begin
                    s_valid <= 1'b1;
                    s_data  <= pending_periods.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each accepted status item against the oldest prediction,
    // field by field. Drive m_ready with random stalls, or a long hold-off
    // whenever the stimulus asks for one.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected status item %h, nothing expected", $time, m_data);
                end else begin
                    status_want = expected_status.pop_front();
                    if (m_data.reset_mask !== status_want.reset_mask) begin
                        error_count++;
                        $display("%0t: reset_mask expected %h got %h",
                                 $time, status_want.reset_mask, m_data.reset_mask);
                    end
                    if (m_data.send_reset !== status_want.send_reset) begin
                        error_count++;
                        $display("%0t: send_reset expected %b got %b",
                                 $time, status_want.send_reset, m_data.send_reset);
                    end
                    if (m_data.synced_mask !== status_want.synced_mask) begin
                        error_count++;
                        $display("%0t: synced_mask expected %h got %h",
                                 $time, status_want.synced_mask, m_data.synced_mask);
                    end
                    if (m_data.send_sync_ack !== status_want.send_sync_ack) begin
                        error_count++;
                        $display("%0t: send_sync_ack expected %b got %b",
                                 $time, status_want.send_sync_ack, m_data.send_sync_ack);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_req_id != hold_seen_id) begin
                hold_seen_id = hold_req_id;
                hold_left    = RX_HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog: end the run if it never drains
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed, reset limits of three. Heartbeats from unsynced nodes
        // reset them, then resync all with an acknowledge.
        queue_period(4'hF, 4'h0);
        queue_period(4'h0, 4'h0);
        queue_period(4'hF, 4'hF);
        // Sync bits while everyone is synced: ignored, no acknowledge
        queue_period(4'hF, 4'hF);
        // Three misses in a row, with sync set on the third: desync and
        // resync in the same period
        queue_period(4'h0, 4'h0);
        queue_period(4'h0, 4'h0);
        queue_period(4'h0, 4'hF);
        // Alternating patterns, then nodes 2 and 3 time out and resync one
        // at a time
        queue_period(4'h5, 4'h0);
        queue_period(4'hA, 4'h0);
        queue_period(4'h3, 4'hC);
        queue_period(4'h3, 4'h0);
        queue_period(4'h3, 4'h0);
        queue_period(4'hC, 4'h0);
        queue_period(4'hF, 4'h4);
        queue_period(4'hF, 4'h8);
        queue_period(4'hF, 4'h0);
        wait_quiet();

        // Extreme limits: zero resets on every miss, one likewise, the
        // maximum never fires here
        program_limits('0, LIMIT_WIDTH'(1), '1, LIMIT_WIDTH'(2));
        queue_period(4'h0, 4'h0);
        queue_period(4'hE, 4'h1);
        queue_period(4'h1, 4'hF);
        queue_period(4'hF, 4'h0);
        queue_period(4'h0, 4'hF);
        queue_period(4'hF, 4'hF);
        wait_quiet();

        // Random small limits, moderate miss rate; sender pause midway
        program_limits(random_limit(), random_limit(), random_limit(), random_limit());
        repeat (75) pending_periods.push_back(random_period(30, 40));
        wait_quiet();
        repeat (75) pending_periods.push_back(random_period(30, 40));
        wait_quiet();

        // Node 0 never answers, with the maximum limit, so its counter climbs
        // all the way. No idling on either side, except one long receiver
        // hold-off at the start while the sender keeps offering.
        program_limits('1, '1, LIMIT_WIDTH'(1), LIMIT_WIDTH'(4));
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        for (int k = 0; k < 280; k++) begin
            pending_periods.push_back(random_period(20, 50));
            pending_periods[k].heartbeat_seen[0] = 1'b0;
        end
        hold_req_id++;
        wait_quiet();
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        // Fully random masks across a few limit settings
        repeat (3) begin
            program_limits(random_limit(), random_limit(), random_limit(), random_limit());
            repeat (40) pending_periods.push_back(random_period(50, 50));
            wait_quiet();
        end

        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule : tb_top

/* files.f */
hw/rtl/nhbs_pkg.sv
hw/rtl/nhbs_node_cell.sv
hw/rtl/node_heartbeat_supervisor.sv
dv/tb_top.sv
